[sv/ebc_pkg.sv]
// ============================================================================
// ebc_pkg: shared types, constants and microcode for the instruction core
// Word formats, memory geometry, opcode dispatch and the control store.
// ============================================================================
`default_nettype none

package ebc_pkg;

  localparam int MemDepth = 65536;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int StepW    = 6;
  localparam int NumSteps = 44;

  // input operations
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SETPC = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // register indexes
  localparam logic CFG_X = 1'b0;
  localparam logic CFG_Y = 1'b1;

  // named opcodes; LDA #imm and ASL A are handled outside the group decode
  localparam logic [7:0] OPC_ADC_IMM = 8'h69;
  localparam logic [7:0] OPC_AND_IMM = 8'h29;
  localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
  localparam logic [7:0] OPC_ASL_ACC = 8'h0A;
  localparam logic [7:0] OPC_BCS     = 8'hB0;

  localparam logic [2:0] GRP_ASL = 3'b000;
  localparam logic [2:0] GRP_AND = 3'b001;
  localparam logic [2:0] GRP_ADC = 3'b011;

  // program entry points
  localparam logic [StepW-1:0] EP_FETCH = 6'd0;
  localparam logic [StepW-1:0] EP_IMM   = 6'd2;
  localparam logic [StepW-1:0] EP_ZP    = 6'd4;
  localparam logic [StepW-1:0] EP_ZPX   = 6'd8;
  localparam logic [StepW-1:0] EP_ABS   = 6'd12;
  localparam logic [StepW-1:0] EP_ABSX  = 6'd17;
  localparam logic [StepW-1:0] EP_ABSY  = 6'd22;
  localparam logic [StepW-1:0] EP_IZX   = 6'd27;
  localparam logic [StepW-1:0] EP_IZY   = 6'd34;
  localparam logic [StepW-1:0] EP_ASLA  = 6'd41;
  localparam logic [StepW-1:0] EP_BR    = 6'd42;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_e;

  typedef enum logic [2:0] {AS_NONE, AS_PC, AS_EA, AS_TMP, AS_TMP1} addr_sel_e;

  typedef enum logic [3:0] {
    TK_NONE, TK_OP, TK_TMP, TK_TMPX, TK_LO, TK_LOX, TK_HI, TK_HIX, TK_HIY
  } take_e;

  typedef struct packed {
    addr_sel_e asel;
    take_e     take;
    logic      alu;
    logic      done;
  } uop_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  accumulator;
    logic        carry;
    logic        zero;
    logic        overflow;
    logic        negative;
    logic        fault;
  } out_word_t;

  typedef struct packed {
    logic c;
    logic z;
    logic v;
    logic n;
  } flags_t;

  function automatic uop_t mk(addr_sel_e a, take_e t, logic alu, logic done);
    uop_t u;
    u.asel = a;
    u.take = t;
    u.alu  = alu;
    u.done = done;
    return u;
  endfunction

  // control store
  function automatic uop_t ucode(logic [StepW-1:0] step);
    uop_t u;
    unique case (step)
      6'd0:  u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd1:  u = mk(AS_NONE, TK_OP,   1'b0, 1'b0);
      6'd2:  u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd3:  u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      6'd4:  u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd5:  u = mk(AS_NONE, TK_LO,   1'b0, 1'b0);
      6'd6:  u = mk(AS_EA,   TK_NONE, 1'b0, 1'b0);
      6'd7:  u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      6'd8:  u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd9:  u = mk(AS_NONE, TK_LOX,  1'b0, 1'b0);
      6'd10: u = mk(AS_EA,   TK_NONE, 1'b0, 1'b0);
      6'd11: u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      6'd12: u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd13: u = mk(AS_PC,   TK_LO,   1'b0, 1'b0);
      6'd14: u = mk(AS_NONE, TK_HI,   1'b0, 1'b0);
      6'd15: u = mk(AS_EA,   TK_NONE, 1'b0, 1'b0);
      6'd16: u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      6'd17: u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd18: u = mk(AS_PC,   TK_LO,   1'b0, 1'b0);
      6'd19: u = mk(AS_NONE, TK_HIX,  1'b0, 1'b0);
      6'd20: u = mk(AS_EA,   TK_NONE, 1'b0, 1'b0);
      6'd21: u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      6'd22: u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd23: u = mk(AS_PC,   TK_LO,   1'b0, 1'b0);
      6'd24: u = mk(AS_NONE, TK_HIY,  1'b0, 1'b0);
      6'd25: u = mk(AS_EA,   TK_NONE, 1'b0, 1'b0);
      6'd26: u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      6'd27: u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd28: u = mk(AS_NONE, TK_TMPX, 1'b0, 1'b0);
      6'd29: u = mk(AS_TMP,  TK_NONE, 1'b0, 1'b0);
      6'd30: u = mk(AS_TMP1, TK_LO,   1'b0, 1'b0);
      6'd31: u = mk(AS_NONE, TK_HI,   1'b0, 1'b0);
      6'd32: u = mk(AS_EA,   TK_NONE, 1'b0, 1'b0);
      6'd33: u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      6'd34: u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd35: u = mk(AS_NONE, TK_TMP,  1'b0, 1'b0);
      6'd36: u = mk(AS_TMP,  TK_NONE, 1'b0, 1'b0);
      6'd37: u = mk(AS_TMP1, TK_LO,   1'b0, 1'b0);
      6'd38: u = mk(AS_NONE, TK_HIY,  1'b0, 1'b0);
      6'd39: u = mk(AS_EA,   TK_NONE, 1'b0, 1'b0);
      6'd40: u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      6'd41: u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      6'd42: u = mk(AS_PC,   TK_NONE, 1'b0, 1'b0);
      6'd43: u = mk(AS_NONE, TK_NONE, 1'b1, 1'b1);
      default: u = mk(AS_NONE, TK_NONE, 1'b0, 1'b1);
    endcase
    return u;
  endfunction

  // opcode to program entry; ok low for unsupported opcodes
  function automatic logic [StepW:0] dispatch(logic [7:0] op);
    logic [StepW-1:0] ep;
    logic             ok;
    ep = EP_FETCH;
    ok = 1'b1;
    unique case (op)
      8'h69, 8'h29, 8'hA9: ep = EP_IMM;
      8'h65, 8'h25, 8'h06: ep = EP_ZP;
      8'h75, 8'h35, 8'h16: ep = EP_ZPX;
      8'h6D, 8'h2D, 8'h0E: ep = EP_ABS;
      8'h7D, 8'h3D, 8'h1E: ep = EP_ABSX;
      8'h79, 8'h39:        ep = EP_ABSY;
      8'h61, 8'h21:        ep = EP_IZX;
      8'h71, 8'h31:        ep = EP_IZY;
      8'h0A:               ep = EP_ASLA;
      8'h90, 8'hB0:        ep = EP_BR;
      default:             ok = 1'b0;
    endcase
    return {ok, ep};
  endfunction

endpackage

`default_nettype wire

[sv/eight_bit_cpu_instruction_core_top.sv]
// ============================================================================
// eight_bit_cpu_instruction_core_top
// Microcoded core for a small ADC/AND/ASL/LDA/BCC/BCS instruction subset.
// ============================================================================
// A load, set-PC or no-op word returns its result word in the next cycle. An
// execute word runs a microprogram from a control store, one step a cycle,
// every memory access going through the byte memory, which has a registered
// read port and a separate write port. A faulting opcode ends the program at
// the step that takes the opcode; the result word is valid on the cycle after
// the last step.
// No input word is taken while an instruction runs or a result word waits.
// After reset the memory is cleared one byte a cycle, all MemDepth bytes
// (65536), during which no input word is taken; index register writes are
// taken at any time.
`default_nettype none

module eight_bit_cpu_instruction_core_top
  import ebc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  state_e            state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [MemAw-1:0]  clr_q;
  logic [15:0]       pc_q, pc_d;
  logic [7:0]        acc_q, acc_d;
  flags_t            flg_q, flg_d;
  logic [15:0]       ea_q, ea_d;
  logic [7:0]        tmp_q, tmp_d;
  logic [7:0]        op_q, op_d;
  logic [7:0]        x_q, y_q;
  logic              out_vld_q, out_vld_d;
  out_word_t         out_q, out_d;

  logic [7:0]        mem_q [MemDepth];
  logic [7:0]        rd_q;
  logic [MemAw-1:0]  raddr, waddr;
  logic              re, we;
  logic [7:0]        wdata;

  uop_t              uop;
  logic [StepW:0]    disp;
  logic              in_acc;
  logic              slot_free;
  logic              fin;
  logic              fault;
  logic [8:0]        sum;
  logic [7:0]        res;
  logic [15:0]       addr16;

  // index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_X) x_q <= cfg_data_i;
      if (cfg_index_i == CFG_Y) y_q <= cfg_data_i;
    end
  end

  // memory: registered read, one write port
  always_ff @(posedge clk_i) begin
    if (re) rd_q <= mem_q[raddr];
    if (we) mem_q[waddr] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
  end

  assign slot_free  = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign uop        = ucode(step_q);
  assign disp       = dispatch(rd_q);

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    pc_d      = pc_q;
    acc_d     = acc_q;
    flg_d     = flg_q;
    ea_d      = ea_q;
    tmp_d     = tmp_q;
    op_d      = op_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    fin       = 1'b0;
    fault     = 1'b0;
    re        = 1'b0;
    we        = 1'b0;
    addr16    = pc_q;
    wdata     = 8'h00;
    waddr     = clr_q;
    sum       = '0;
    res       = '0;

    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        if (clr_q == MemAw'(MemDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_word_i.operation)
            OP_LOAD: begin
              we    = 1'b1;
              waddr = in_word_i.address[MemAw-1:0];
              wdata = in_word_i.data;
              fin   = 1'b1;
            end
            OP_SETPC: begin
              pc_d = in_word_i.address;
              fin  = 1'b1;
            end
            OP_EXEC: begin
              state_d = ST_RUN;
              step_d  = EP_FETCH;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_RUN: begin
        step_d = step_q + 1'b1;
        // issue read
        unique case (uop.asel)
          AS_PC:   begin re = 1'b1; addr16 = pc_q; pc_d = pc_q + 16'd1; end
          AS_EA:   begin re = 1'b1; addr16 = ea_q; end
          AS_TMP:  begin re = 1'b1; addr16 = {8'h00, tmp_q}; end
          AS_TMP1: begin re = 1'b1; addr16 = {8'h00, tmp_q + 8'd1}; end
          default: re = 1'b0;
        endcase
        // take data read in the previous step
        unique case (uop.take)
          TK_OP: begin
            op_d = rd_q;
            if (disp[StepW]) step_d = disp[StepW-1:0];
            else begin
              fault = 1'b1;
              fin   = 1'b1;
            end
          end
          TK_TMP:  tmp_d = rd_q;
          TK_TMPX: tmp_d = rd_q + x_q;
          TK_LO:   ea_d  = {8'h00, rd_q};
          TK_LOX:  ea_d  = {8'h00, rd_q + x_q};
          TK_HI:   ea_d  = {rd_q, ea_q[7:0]};
          TK_HIX:  ea_d  = {rd_q, ea_q[7:0]} + {8'h00, x_q};
          TK_HIY:  ea_d  = {rd_q, ea_q[7:0]} + {8'h00, y_q};
          default: ;
        endcase
        // execute on the operand
        if (uop.alu) begin
          if (op_q == OPC_LDA_IMM) begin
            acc_d = rd_q;
            flg_d.z = (rd_q == 8'h00);
            flg_d.n = rd_q[7];
          end else if (op_q == OPC_ASL_ACC) begin
            res     = {acc_q[6:0], 1'b0};
            acc_d   = res;
            flg_d.c = acc_q[7];
            flg_d.z = (res == 8'h00);
            flg_d.n = res[7];
          end else begin
            case (op_q[7:5])
              GRP_ADC: begin
                sum     = {1'b0, acc_q} + {1'b0, rd_q} + {8'h00, flg_q.c};
                res     = sum[7:0];
                acc_d   = res;
                flg_d.c = sum[8];
                flg_d.v = ~(acc_q[7] ^ rd_q[7]) & (acc_q[7] ^ res[7]);
                flg_d.z = (res == 8'h00);
                flg_d.n = res[7];
              end
              GRP_AND: begin
                res     = acc_q & rd_q;
                acc_d   = res;
                flg_d.z = (res == 8'h00);
                flg_d.n = res[7];
              end
              GRP_ASL: begin
                // write back the shifted byte to the operand address
                res     = {rd_q[6:0], 1'b0};
                we      = 1'b1;
                waddr   = ea_q[MemAw-1:0];
                wdata   = res;
                flg_d.c = rd_q[7];
                flg_d.z = (res == 8'h00);
                flg_d.n = res[7];
              end
              default: begin
                if (flg_q.c == (op_q == OPC_BCS))
                  pc_d = pc_q + {{8{rd_q[7]}}, rd_q};
              end
            endcase
          end
        end
        if (uop.done) fin = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase

    if (fin) begin
      if (state_q == ST_RUN) state_d = ST_IDLE;
      out_vld_d            = 1'b1;
      out_d.pc             = pc_d;
      out_d.accumulator    = acc_d;
      out_d.carry          = flg_d.c;
      out_d.zero           = flg_d.z;
      out_d.overflow       = flg_d.v;
      out_d.negative       = flg_d.n;
      out_d.fault          = fault;
    end
    raddr = addr16[MemAw-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      step_q    <= '0;
      pc_q      <= '0;
      acc_q     <= '0;
      flg_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      pc_q      <= pc_d;
      acc_q     <= acc_d;
      flg_q     <= flg_d;
      out_vld_q <= out_vld_d;
    end
  end

  // datapath scratch and output word hold their values
  always_ff @(posedge clk_i) begin
    ea_q  <= ea_d;
    tmp_q <= tmp_d;
    op_q  <= op_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_no_result_while_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !out_vld_q)
    else $error("result word pending during instruction");
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("input taken during memory clear");
  a_step_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q < StepW'(NumSteps)))
    else $error("microprogram step out of range");
  a_exec_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.operation == OP_EXEC) |=> (state_q == ST_RUN && step_q == EP_FETCH))
    else $error("execute word did not start fetch");
`endif

endmodule

`default_nettype wire

[tb/tb_checker.sv]
// ============================================================================
// tb_checker: result predictor and scoreboard for the instruction core
// Watches both channels, predicts each result word and compares it as a whole.
// ============================================================================
`default_nettype none

module tb_checker
  import ebc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_word_t  in_word_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_word_t out_word_i,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  mem_q [MemDepth];
  logic [15:0] pc_q;
  logic [7:0]  acc_q;
  flags_t      flg_q;
  logic [7:0]  x_q, y_q;
  out_word_t   expected_q[$];

  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = mem_q[pc_q];
    pc_q = pc_q + 16'd1;
    return b;
  endfunction

  function automatic logic [15:0] fetch_word();
    logic [7:0] lo;
    lo = fetch_byte();
    return {fetch_byte(), lo};
  endfunction

  function automatic logic [15:0] zp_pointer(logic [7:0] zp);
    logic [7:0] nxt;
    nxt = zp + 8'd1;
    return {mem_q[nxt], mem_q[zp]};
  endfunction

  function automatic logic [15:0] operand_addr(logic [2:0] mode);
    logic [7:0] z;
    case (mode)
      3'd0: begin z = fetch_byte() + x_q; return zp_pointer(z); end
      3'd1: return {8'h00, fetch_byte()};
      3'd3: return fetch_word();
      3'd4: return zp_pointer(fetch_byte()) + {8'h00, y_q};
      3'd5: begin z = fetch_byte() + x_q; return {8'h00, z}; end
      3'd6: return fetch_word() + {8'h00, y_q};
      default: return fetch_word() + {8'h00, x_q};
    endcase
  endfunction

  function automatic void set_zn(logic [7:0] v);
    flg_q.z = (v == 8'h00);
    flg_q.n = v[7];
  endfunction

  function automatic void add_carry(logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, acc_q} + {1'b0, m} + {8'h00, flg_q.c};
    flg_q.c = sum[8];
    flg_q.v = ~(acc_q[7] ^ m[7]) & (acc_q[7] ^ sum[7]);
    acc_q = sum[7:0];
    set_zn(acc_q);
  endfunction

  function automatic logic [7:0] shift_left(logic [7:0] v);
    flg_q.c = v[7];
    set_zn({v[6:0], 1'b0});
    return {v[6:0], 1'b0};
  endfunction

  // run one instruction at pc; return 1 on an unsupported opcode
  function automatic logic run_instr();
    logic [7:0]  opc, off;
    logic [15:0] ea;
    opc = fetch_byte();
    case (opc)
      OPC_ADC_IMM: add_carry(fetch_byte());
      8'h61, 8'h65, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D:
        add_carry(mem_q[operand_addr(opc[4:2])]);
      OPC_AND_IMM: begin acc_q &= fetch_byte(); set_zn(acc_q); end
      8'h21, 8'h25, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: begin
        acc_q &= mem_q[operand_addr(opc[4:2])];
        set_zn(acc_q);
      end
      OPC_ASL_ACC: acc_q = shift_left(acc_q);
      8'h06, 8'h16, 8'h0E, 8'h1E: begin
        ea = operand_addr(opc == 8'h06 ? 3'd1 : opc == 8'h16 ? 3'd5 :
                          opc == 8'h0E ? 3'd3 : 3'd7);
        mem_q[ea] = shift_left(mem_q[ea]);
      end
      OPC_LDA_IMM: begin acc_q = fetch_byte(); set_zn(acc_q); end
      8'h90, OPC_BCS: begin
        off = fetch_byte();
        if (flg_q.c == (opc == OPC_BCS)) pc_q = pc_q + {{8{off[7]}}, off};
      end
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    logic      flt;
    flt = 1'b0;
    case (w.operation)
      OP_LOAD:  mem_q[w.address] = w.data;
      OP_SETPC: pc_q = w.address;
      OP_EXEC:  flt = run_instr();
      default: ;
    endcase
    r.pc = pc_q; r.accumulator = acc_q;
    r.carry = flg_q.c; r.zero = flg_q.z; r.overflow = flg_q.v; r.negative = flg_q.n;
    r.fault = flt;
    return r;
  endfunction

  initial begin
    foreach (mem_q[i]) mem_q[i] = 8'h00;
    pc_q = '0; acc_q = '0; flg_q = '0; x_q = '0; y_q = '0;
    fail_count_o = 0;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_X) x_q <= cfg_data_i;
        else y_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_word(in_word_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result word %p", out_word_i);
        end else begin
          e = expected_q.pop_front();
          if (e !== out_word_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: expected %p got %p", e, out_word_i);
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

[tb/tb_top.sv]
// ============================================================================
// tb_top: stimulus and verdict for the instruction core
// Drives directed and random programs, index writes and random idling.
// ============================================================================
`default_nettype none

module tb_top;
  import ebc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic      cfg_index = CFG_X;
  logic [7:0] cfg_data = '0;
  int        fail_count, pending;
  logic      calm = 1'b0;  // no idling on either side while set

  always #2 clk = ~clk;

  eight_bit_cpu_instruction_core_top dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_word_i(in_word), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_word_o(out_word), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data));

  tb_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_word_i(in_word), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_word_i(out_word), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .fail_count_o(fail_count), .pending_o(pending));

  // receiver: stall about a quarter of the cycles unless calm
  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 25);

  // hand one word over; optionally idle first, then hold valid until taken
  task automatic send_word(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{operation: op, address: addr, data: data};
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid after the last word and wait for every result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  task automatic load_byte(logic [15:0] addr, logic [7:0] data);
    send_word(OP_LOAD, addr, data);
  endtask

  task automatic exec_at(logic [15:0] addr);
    send_word(OP_SETPC, addr, 8'($urandom_range(255)));
    send_word(OP_EXEC, 16'($urandom), 8'($urandom_range(255)));
  endtask

  // drain, let the core settle, then write an index register
  task automatic write_index(logic idx, logic [7:0] val);
    drain();
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // build one instruction with random operands at a random place, then run it
  task automatic random_instr();
    logic [7:0]  opc;
    logic [15:0] pc;
    int          k;
    logic [7:0]  ops[13];
    ops = '{8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D,
            8'h21, 8'h25, 8'h29, 8'h2D, 8'h0A};
    k = $urandom_range(99);
    if (k < 40) opc = ops[$urandom_range(12)];
    else if (k < 55) opc = ops[$urandom_range(12)] & 8'hDF;
    else if (k < 70) opc = k[0] ? (k[1] ? 8'h06 : 8'h16) : (k[1] ? 8'h0E : 8'h1E);
    else if (k < 80) opc = k[0] ? 8'h90 : OPC_BCS;
    else if (k < 87) opc = OPC_LDA_IMM;
    else opc = 8'($urandom_range(255));
    pc = ($urandom_range(3) == 0) ? 16'hFFFE + 16'($urandom_range(3)) : 16'($urandom);
    load_byte(pc, opc);
    load_byte(pc + 16'd1, 8'($urandom_range(255)));
    load_byte(pc + 16'd2, 8'($urandom_range(255)));
    // seed the pointer and data areas that the operands tend to hit
    if ($urandom_range(1))
      load_byte(16'($urandom_range(255)), 8'($urandom_range(255)));
    exec_at(pc);
    if ($urandom_range(2) == 0)
      send_word(OP_EXEC, 16'($urandom), 8'($urandom_range(255)));
    if ($urandom_range(40) == 0)
      send_word(OP_NOP, 16'($urandom), 8'($urandom_range(255)));
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: LDA, ADC, branches, ASL A, an unsupported opcode and wrap corners
    write_index(CFG_X, 8'hFF);
    write_index(CFG_Y, 8'h00);
    load_byte(16'h0000, OPC_LDA_IMM); load_byte(16'h0001, 8'h7F);
    load_byte(16'h0002, OPC_ADC_IMM); load_byte(16'h0003, 8'h01);   // signed overflow
    load_byte(16'h0004, OPC_ADC_IMM); load_byte(16'h0005, 8'h80);   // carry out
    load_byte(16'h0006, OPC_BCS);     load_byte(16'h0007, 8'h80);   // taken, backward
    send_word(OP_SETPC, 16'h0000, 8'h00);
    repeat (4) send_word(OP_EXEC, 16'hFFFF, 8'hFF);
    load_byte(16'hFFFF, 8'h90); load_byte(16'h0000, 8'h05);         // pc wrap on fetch
    exec_at(16'hFFFF);
    load_byte(16'h00FF, 8'h34);       load_byte(16'h0000, 8'h12);   // zp pointer wrap
    load_byte(16'h1000, 8'h61); load_byte(16'h1001, 8'h00);         // (zp,X) wraps
    exec_at(16'h1000);
    load_byte(16'h1000, 8'h02); exec_at(16'h1000);                  // unsupported
    load_byte(16'h1000, OPC_ASL_ACC); exec_at(16'h1000);
    send_word(OP_NOP, 16'hFFFF, 8'hFF);

    // random phases with different index settings
    calm = 1'b1;
    for (n = 0; n < 45; n++) random_instr();  // stretch with no idling
    calm = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      write_index(CFG_X, ph == 0 ? 8'h00 : ph == 1 ? 8'hFF : 8'($urandom_range(255)));
      write_index(CFG_Y, ph == 0 ? 8'hFF : ph == 1 ? 8'h00 : 8'($urandom_range(255)));
      for (n = 0; n < 45; n++) random_instr();
    end
    drain();  // hold off until every result has come
    for (n = 0; n < 40; n++) random_instr();

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // the memory clear and the rest of the run stay far below this bound
  initial begin
    #3ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire

[sim.f]
sv/ebc_pkg.sv
sv/eight_bit_cpu_instruction_core_top.sv
tb/tb_checker.sv
tb/tb_top.sv
